// ===== rtl/core/qmd_pkg.sv =====
// shared widths, register indexes and helpers for the quad motor mixer
package qmd_pkg;

   // field widths
   localparam int ERR_W   = 24;
   localparam int THR_W   = 17;
   localparam int REV_W   = 17;
   localparam int MOT_W   = 17;
   localparam int RANGE_W = REV_W + 1;

   // floored thrust, wide enough for any fraction width in range
   localparam int T_W = 26;

   // working width of the clamp helper
   localparam int CL_W = 96;

   // default fixed point fraction width
   localparam int FRAC_BITS_DEF = 16;

   // stream widths, padded to whole bytes
   localparam int REQ_W = 96;
   localparam int RSP_W = 72;

   // configuration port
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_REV = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_REV = 8'd1;
   localparam logic [REV_W-1:0] MIN_REV_RST = 17'd0;
   localparam logic [REV_W-1:0] MAX_REV_RST = 17'd65536;

   // clamp a command to [0, one] and keep the low command bits
   function automatic logic [MOT_W-1:0] clamp_cmd(input logic signed [CL_W-1:0] v,
                                                   input logic signed [CL_W-1:0] one);
      logic signed [CL_W-1:0] c;
      c = (v < 0) ? '0 : ((v > one) ? one : v);
      return c[MOT_W-1:0];
   endfunction

endpackage

// ===== rtl/core/qmd_div.sv =====
// pipelined restoring divider, several numerators over one shared divisor
module qmd_div #(
   parameter int LANES = 3,
   parameter int NUM_W = 40,
   parameter int DEN_W = 28,
   parameter int SB_W  = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num [LANES],
   input  logic [DEN_W-1:0] in_den,
   input  logic [SB_W-1:0]  in_sb,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo [LANES],
   output logic [SB_W-1:0]  out_sb
);

   localparam int STEPS = NUM_W;

   logic             vld_ff [STEPS+1];
   logic [NUM_W-1:0] q_ff   [STEPS+1][LANES];
   logic [DEN_W-1:0] r_ff   [STEPS+1][LANES];
   logic             neg_ff [STEPS+1][LANES];
   logic [DEN_W-1:0] den_ff [STEPS+1];
   logic [SB_W-1:0]  sb_ff  [STEPS+1];

   logic [NUM_W-1:0] mag_in [LANES];
   logic             neg_in [LANES];

   logic             out_vld_ff;
   logic [NUM_W-1:0] out_quo_ff [LANES];
   logic [NUM_W-1:0] out_quo_in [LANES];
   logic [SB_W-1:0]  out_sb_ff;

   // split numerators into sign and magnitude
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         neg_in[l] = in_num[l][NUM_W-1];
         mag_in[l] = neg_in[l] ? (~in_num[l] + 1'b1) : in_num[l];
      end
   end

   // load stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            q_ff[0][l]   <= mag_in[l];
            r_ff[0][l]   <= '0;
            neg_ff[0][l] <= neg_in[l];
         end
         den_ff[0] <= in_den;
         sb_ff[0]  <= in_sb;
      end
   end

   // one quotient bit per stage
   for (genvar s = 0; s < STEPS; s++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (en) begin
            vld_ff[s+1] <= vld_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[s+1] <= den_ff[s];
            sb_ff[s+1]  <= sb_ff[s];
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DEN_W:0]   trial;
         logic             ge;
         logic [DEN_W:0]   r_in;
         logic [NUM_W-1:0] q_in;

         assign trial = {r_ff[s][l], q_ff[s][l][NUM_W-1]};
         assign ge    = trial >= {1'b0, den_ff[s]};
         assign r_in  = ge ? (trial - {1'b0, den_ff[s]}) : trial;
         assign q_in  = {q_ff[s][l][NUM_W-2:0], ge};

         always_ff @(posedge clock) begin
            if (en) begin
               q_ff[s+1][l]   <= q_in;
               r_ff[s+1][l]   <= r_in[DEN_W-1:0];
               neg_ff[s+1][l] <= neg_ff[s][l];
            end
         end
      end
   end

   // restore the sign, truncated toward zero
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quo_in[l] = neg_ff[STEPS][l] ? (~q_ff[STEPS][l] + 1'b1) : q_ff[STEPS][l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_quo_ff <= out_quo_in;
         out_sb_ff  <= sb_ff[STEPS];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_quo   = out_quo_ff;
   assign out_sb    = out_sb_ff;

endmodule

// ===== rtl/core/qmd_desat.sv =====
// desaturation pipeline: shift up, shift down, rescale product
module qmd_desat #(
   parameter int M_W       = 44,
   parameter int SP_W      = 45,
   parameter int P_W       = 63,
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [M_W-1:0]    in_m [4],
   input  logic [qmd_pkg::REV_W-1:0] min_rev,
   input  logic [qmd_pkg::REV_W-1:0] max_rev,
   output logic                     out_valid,
   output logic [P_W-1:0]           out_num [4],
   output logic [SP_W-1:0]          out_spread,
   output logic [qmd_pkg::MOT_W-1:0] out_fixed [4],
   output logic                     out_use
);

   localparam int CL_W = qmd_pkg::CL_W;
   localparam logic signed [CL_W-1:0] ONE_CL = CL_W'(1) << FRAC_BITS;

   logic vld_ff [8];

   logic signed [M_W-1:0] m0_ff [4];
   logic signed [M_W-1:0] m1_ff [4];
   logic signed [M_W-1:0] mn1_ff, mn1_in;
   logic signed [M_W-1:0] m2_ff [4];
   logic signed [M_W-1:0] m2_in [4];
   logic signed [M_W-1:0] m3_ff [4];
   logic signed [M_W-1:0] mx3_ff, mx3_in;
   logic signed [M_W-1:0] m4_ff [4];
   logic signed [M_W-1:0] m4_in [4];
   logic signed [M_W-1:0] m5_ff [4];
   logic signed [M_W-1:0] mn5_ff, mn5_in, mx5_ff, mx5_in;
   logic signed [SP_W-1:0] diff6_ff [4];
   logic signed [SP_W-1:0] diff6_in [4];
   logic signed [SP_W-1:0] spread6_ff, spread6_in;
   logic signed [qmd_pkg::RANGE_W-1:0] range6_ff, range6_in;
   logic [qmd_pkg::MOT_W-1:0] fixed6_ff [4];
   logic [qmd_pkg::MOT_W-1:0] fixed6_in [4];
   logic use6_ff, use6_in;
   logic signed [P_W-1:0] num7_ff [4];
   logic signed [P_W-1:0] num7_in [4];
   logic [SP_W-1:0] spread7_ff;
   logic [qmd_pkg::MOT_W-1:0] fixed7_ff [4];
   logic use7_ff;

   logic signed [M_W-1:0] lo_m, hi_m;
   logic rescale, zero;

   assign lo_m = $signed({{(M_W-qmd_pkg::REV_W){1'b0}}, min_rev});
   assign hi_m = $signed({{(M_W-qmd_pkg::REV_W){1'b0}}, max_rev});

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 8; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s < 8; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   // smallest command
   always_comb begin
      mn1_in = m0_ff[0];
      for (int i = 1; i < 4; i++) if (m0_ff[i] < mn1_in) mn1_in = m0_ff[i];
   end

   // shift up to the low limit
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         m2_in[i] = m1_ff[i] + ((mn1_ff < lo_m) ? (lo_m - mn1_ff) : '0);
      end
   end

   // largest command
   always_comb begin
      mx3_in = m2_ff[0];
      for (int i = 1; i < 4; i++) if (m2_ff[i] > mx3_in) mx3_in = m2_ff[i];
   end

   // shift down to the high limit
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         m4_in[i] = m3_ff[i] - ((mx3_ff > hi_m) ? (mx3_ff - hi_m) : '0);
      end
   end

   // fresh min and max after the shifts
   always_comb begin
      mn5_in = m4_ff[0];
      mx5_in = m4_ff[0];
      for (int i = 1; i < 4; i++) begin
         if (m4_ff[i] < mn5_in) mn5_in = m4_ff[i];
         if (m4_ff[i] > mx5_in) mx5_in = m4_ff[i];
      end
   end

   // rescale decision, spread and offsets
   assign rescale    = (mn5_ff < lo_m) || (mx5_ff > hi_m);
   assign spread6_in = SP_W'(mx5_ff) - SP_W'(mn5_ff);
   assign zero       = (spread6_in == '0);
   assign use6_in    = rescale && !zero;
   assign range6_in  = $signed({1'b0, max_rev}) - $signed({1'b0, min_rev});

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         diff6_in[i]  = SP_W'(m5_ff[i]) - SP_W'(mn5_ff);
         fixed6_in[i] = (rescale && zero) ? qmd_pkg::clamp_cmd(CL_W'(hi_m), ONE_CL)
                                          : qmd_pkg::clamp_cmd(CL_W'(m5_ff[i]), ONE_CL);
      end
   end

   // offset times target window
   always_comb begin
      for (int i = 0; i < 4; i++) num7_in[i] = diff6_ff[i] * range6_ff;
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         m0_ff      <= in_m;
         m1_ff      <= m0_ff;
         mn1_ff     <= mn1_in;
         m2_ff      <= m2_in;
         m3_ff      <= m2_ff;
         mx3_ff     <= mx3_in;
         m4_ff      <= m4_in;
         m5_ff      <= m4_ff;
         mn5_ff     <= mn5_in;
         mx5_ff     <= mx5_in;
         diff6_ff   <= diff6_in;
         spread6_ff <= spread6_in;
         range6_ff  <= range6_in;
         fixed6_ff  <= fixed6_in;
         use6_ff    <= use6_in;
         num7_ff    <= num7_in;
         spread7_ff <= spread6_ff;
         fixed7_ff  <= fixed6_ff;
         use7_ff    <= use6_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) out_num[i] = num7_ff[i];
   end

   assign out_valid  = vld_ff[7];
   assign out_spread = spread7_ff;
   assign out_fixed  = fixed7_ff;
   assign out_use    = use7_ff;

endmodule

// ===== rtl/core/quad_motor_mixer_desaturate_unit.sv =====
// top level of the quad motor mixer with desaturation
//
//  channel  dir  handshake               payload
//  req      in   req_tvalid/req_tready   err_x, err_y, err_z, thrust
//  rsp      out  rsp_tvalid/rsp_tready   motor_one .. motor_four
//  csr      in   csr_valid/csr_ready     csr_index, csr_data (min_rev, max_rev)
//
// one beat enters per cycle while the output is not stalled; the pipeline runs
// through two bit-per-stage dividers (deltas, then rescale)
// synchronous reset clears valid bits and loads the window registers
// a stalled output freezes the whole pipeline; req_tready drops with it
module quad_motor_mixer_desaturate_unit #(
   parameter int FRAC_BITS = qmd_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // err_x[23:0], err_y[47:24], err_z[71:48], thrust[88:72], zero pad
   input  logic [qmd_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // motor_one[16:0], motor_two[33:17], motor_three[50:34], motor_four[67:51], pad
   output logic [qmd_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [qmd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [qmd_pkg::REV_W-1:0]     csr_data
);

   localparam int ERR_W  = qmd_pkg::ERR_W;
   localparam int T_W    = qmd_pkg::T_W;
   localparam int MOT_W  = qmd_pkg::MOT_W;
   localparam int CL_W   = qmd_pkg::CL_W;
   localparam int NUM_W  = ERR_W + FRAC_BITS;
   localparam int DEN_W  = T_W + 2;
   localparam int M_W    = NUM_W + 4;
   localparam int SP_W   = M_W + 1;
   localparam int P_W    = SP_W + qmd_pkg::RANGE_W;
   localparam int SB2_W  = 4 * MOT_W + 1;
   localparam int THRUST_MIN = ((1 << FRAC_BITS) + 50) / 100;
   localparam logic [T_W-1:0] T_MIN = T_W'(THRUST_MIN);
   localparam logic signed [CL_W-1:0] ONE_CL = CL_W'(1) << FRAC_BITS;

   logic en;

   logic [qmd_pkg::REV_W-1:0] min_rev_ff, max_rev_ff;

   logic [ERR_W-1:0] err_x, err_y, err_z;
   logic [qmd_pkg::THR_W-1:0] thrust;
   logic [T_W-1:0] t_raw, t_fl;
   logic [NUM_W-1:0] d_num [3];

   logic             d_valid;
   logic [NUM_W-1:0] d_quo [3];
   logic [T_W-1:0]   d_t;
   logic signed [M_W-1:0] mix_m [4];
   logic signed [M_W-1:0] tm, dx, dy, dz;

   logic             s_valid;
   logic [P_W-1:0]   s_num [4];
   logic [SP_W-1:0]  s_spread;
   logic [MOT_W-1:0] s_fixed [4];
   logic             s_use;
   logic [SB2_W-1:0] s_sb;

   logic             r_valid;
   logic [P_W-1:0]   r_quo [4];
   logic [SB2_W-1:0] r_sb;
   logic [MOT_W-1:0] mot_in [4];

   logic             rsp_valid_ff;
   logic [MOT_W-1:0] mot_ff [4];

   // pipeline advances unless the output beat is held
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   // window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_rev_ff <= qmd_pkg::MIN_REV_RST;
         max_rev_ff <= qmd_pkg::MAX_REV_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            qmd_pkg::CSR_MIN_REV: min_rev_ff <= csr_data;
            qmd_pkg::CSR_MAX_REV: max_rev_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // unpack request, floor thrust, scale numerators
   assign err_x  = req_tdata[ERR_W-1:0];
   assign err_y  = req_tdata[2*ERR_W-1:ERR_W];
   assign err_z  = req_tdata[3*ERR_W-1:2*ERR_W];
   assign thrust = req_tdata[3*ERR_W+qmd_pkg::THR_W-1:3*ERR_W];
   assign t_raw  = T_W'(thrust);
   assign t_fl   = (t_raw < T_MIN) ? T_MIN : t_raw;

   // yaw over 8T is half its numerator over 4T
   assign d_num[0] = {err_x, {FRAC_BITS{1'b0}}};
   assign d_num[1] = {err_y, {FRAC_BITS{1'b0}}};
   assign d_num[2] = {err_z[ERR_W-1], err_z, {(FRAC_BITS-1){1'b0}}};

   qmd_div #(
      .LANES(3), .NUM_W(NUM_W), .DEN_W(DEN_W), .SB_W(T_W)
   ) u_delta_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_num   (d_num),
      .in_den   ({t_fl, 2'b00}),
      .in_sb    (t_fl),
      .out_valid(d_valid),
      .out_quo  (d_quo),
      .out_sb   (d_t)
   );

   // plus-layout mix
   assign tm = $signed(M_W'(d_t));
   assign dx = M_W'($signed(d_quo[0]));
   assign dy = M_W'($signed(d_quo[1]));
   assign dz = M_W'($signed(d_quo[2]));
   assign mix_m[0] = tm - dy - dz;
   assign mix_m[1] = tm - dx + dz;
   assign mix_m[2] = tm + dy - dz;
   assign mix_m[3] = tm + dx + dz;

   qmd_desat #(
      .M_W(M_W), .SP_W(SP_W), .P_W(P_W), .FRAC_BITS(FRAC_BITS)
   ) u_desat (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_m      (mix_m),
      .min_rev   (min_rev_ff),
      .max_rev   (max_rev_ff),
      .out_valid (s_valid),
      .out_num   (s_num),
      .out_spread(s_spread),
      .out_fixed (s_fixed),
      .out_use   (s_use)
   );

   assign s_sb = {s_use, s_fixed[3], s_fixed[2], s_fixed[1], s_fixed[0]};

   qmd_div #(
      .LANES(4), .NUM_W(P_W), .DEN_W(SP_W), .SB_W(SB2_W)
   ) u_rescale_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s_valid),
      .in_num   (s_num),
      .in_den   (s_spread),
      .in_sb    (s_sb),
      .out_valid(r_valid),
      .out_quo  (r_quo),
      .out_sb   (r_sb)
   );

   // pick rescaled or passed command, then clamp
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mot_in[i] = r_sb[SB2_W-1]
            ? qmd_pkg::clamp_cmd(CL_W'(min_rev_ff) + CL_W'($signed(r_quo[i])), ONE_CL)
            : r_sb[i*MOT_W +: MOT_W];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= r_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mot_ff <= mot_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(qmd_pkg::RSP_W - 4*MOT_W){1'b0}},
                        mot_ff[3], mot_ff[2], mot_ff[1], mot_ff[0]};

   // a held output beat blocks new input
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while output stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   // a min_rev window write lands in the register
   a_min_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == qmd_pkg::CSR_MIN_REV)
      |=> min_rev_ff == $past(csr_data))
      else $error("min_rev write lost");

   // commands never exceed full scale
   a_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (FRAC_BITS <= 16) |->
      (CL_W'(mot_ff[0]) <= ONE_CL) && (CL_W'(mot_ff[1]) <= ONE_CL) &&
      (CL_W'(mot_ff[2]) <= ONE_CL) && (CL_W'(mot_ff[3]) <= ONE_CL))
      else $error("motor command above full scale");

endmodule
